/* hw/rtl/hvt_pkg.sv */
// hvt_pkg: shared types, widths and command codes of the homogeneous vertex transform.
// Depends on nothing; every other file in hw/rtl uses it through scoped names.
`timescale 1ns / 1ps

package hvt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIM       = 4;
	localparam int IDX_W     = $clog2(DIM);
	localparam int WORD_W    = 32;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int SHR_W     = SUM_W - FRAC_BITS;
	localparam int HALF      = DIM / 2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t [DIM-1:0]          vec_t;
	typedef word_t [DIM-1:0][DIM-1:0] mat_t;   // [row][col]
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_XFORM = 1'b1
	} cmd_t;

	// full-precision column sums leaving the dot-product pipe
	typedef struct packed {
		logic             valid;
		sum_t [DIM-1:0]   sum;
	} sum_beat_t;

	localparam word_t ONE      = word_t'(64'sd1 <<< FRAC_BITS);
	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	function automatic mat_t identity_mat();
		mat_t m;
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				m[r][c] = (r == c) ? ONE : '0;
			end
		end
		return m;
	endfunction

endpackage

/* hw/rtl/hvt_coef_store.sv */
// hvt_coef_store: 4x4 coefficient register file, resets to identity.
// Depends on hvt_pkg.
`timescale 1ns / 1ps

module hvt_coef_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [hvt_pkg::IDX_W-1:0] wr_row,
	input  logic [hvt_pkg::IDX_W-1:0] wr_col,
	input  hvt_pkg::word_t           wr_value,
	output hvt_pkg::mat_t            matrix
);

	hvt_pkg::mat_t mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= hvt_pkg::identity_mat();
		end else if (wr_en) begin
			mat_q[wr_row][wr_col] <= wr_value;
		end
	end

	assign matrix = mat_q;

endmodule

/* hw/rtl/hvt_dot.sv */
// hvt_dot: three-stage dot-product pipe (products, pair sums, column sums).
// Depends on hvt_pkg.
`timescale 1ns / 1ps

module hvt_dot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  hvt_pkg::vec_t      vec,
	input  hvt_pkg::mat_t      matrix,
	output logic               ready_in,
	input  logic               ready_out,
	output hvt_pkg::sum_beat_t beat
);

	logic signed [hvt_pkg::PROD_W-1:0] prod_s1 [hvt_pkg::DIM][hvt_pkg::DIM];  // [row][col]
	logic signed [hvt_pkg::PAIR_W-1:0] pair_s2 [hvt_pkg::DIM][hvt_pkg::HALF];  // [col][half]
	hvt_pkg::sum_t                     sum_s3  [hvt_pkg::DIM];
	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	// a stage takes new data when empty or when its contents move on
	assign rdy_s3   = !valid_s3 || ready_out;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign ready_in = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= load;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int k = 0; k < hvt_pkg::DIM; k++) begin
				for (int c = 0; c < hvt_pkg::DIM; c++) begin
					prod_s1[k][c] <= hvt_pkg::PROD_W'(vec[k]) *
						hvt_pkg::PROD_W'(matrix[k][c]);
				end
			end
		end
		if (rdy_s2) begin
			for (int c = 0; c < hvt_pkg::DIM; c++) begin
				for (int h = 0; h < hvt_pkg::HALF; h++) begin
					pair_s2[c][h] <= hvt_pkg::PAIR_W'(prod_s1[2*h][c]) +
						hvt_pkg::PAIR_W'(prod_s1[2*h+1][c]);
				end
			end
		end
		if (rdy_s3) begin
			for (int c = 0; c < hvt_pkg::DIM; c++) begin
				sum_s3[c] <= hvt_pkg::SUM_W'(pair_s2[c][0]) +
					hvt_pkg::SUM_W'(pair_s2[c][1]);
			end
		end
	end

	always_comb begin
		beat.valid = valid_s3;
		for (int c = 0; c < hvt_pkg::DIM; c++) begin
			beat.sum[c] = sum_s3[c];
		end
	end

endmodule

/* hw/rtl/hvt_sat.sv */
// hvt_sat: arithmetic shift by FRAC_BITS, saturation to 32 bits, output register.
// Depends on hvt_pkg.
`timescale 1ns / 1ps

module hvt_sat (
	input  logic               clk,
	input  logic               arst_n,
	input  hvt_pkg::sum_beat_t beat,
	output logic               ready_in,
	output logic               out_valid,
	input  logic               out_stall,
	output hvt_pkg::vec_t      result,
	output logic               overflow
);

	hvt_pkg::vec_t sat_val;
	logic [hvt_pkg::DIM-1:0] sat_hit;
	hvt_pkg::vec_t res_s4;
	logic          ovf_s4;
	logic          valid_s4;

	always_comb begin
		logic [hvt_pkg::SHR_W-1:0]        shr;
		logic [hvt_pkg::SHR_W-hvt_pkg::WORD_W:0] top;
		for (int c = 0; c < hvt_pkg::DIM; c++) begin
			shr = beat.sum[c][hvt_pkg::SUM_W-1:hvt_pkg::FRAC_BITS];
			top = shr[hvt_pkg::SHR_W-1:hvt_pkg::WORD_W-1];
			sat_hit[c] = (top != '0) && (top != '1);
			if (!sat_hit[c]) begin
				sat_val[c] = hvt_pkg::word_t'(shr[hvt_pkg::WORD_W-1:0]);
			end else if (shr[hvt_pkg::SHR_W-1]) begin
				sat_val[c] = hvt_pkg::WORD_MIN;
			end else begin
				sat_val[c] = hvt_pkg::WORD_MAX;
			end
		end
	end

	assign ready_in = !valid_s4 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_in) begin
			valid_s4 <= beat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_in) begin
			res_s4 <= sat_val;
			ovf_s4 <= |sat_hit;
		end
	end

	assign out_valid = valid_s4;
	assign result    = res_s4;
	assign overflow  = ovf_s4;

endmodule

/* hw/rtl/homogeneous_vertex_transform.sv */
// Homogeneous 4x4 vertex transform, signed Q16.16: out[c] = sum_k v[k] * M[k][c].
// An accepted transform beat passes the product, pair-sum, column-sum and
// shift/saturate registers to its result beat; one beat per cycle unless stalled.
// Coefficient write beats finish at acceptance and produce no result beat.
// Reset (arst_n low, async): pipeline emptied, matrix back to identity.
// Depends on hvt_pkg, hvt_coef_store, hvt_dot, hvt_sat.
`timescale 1ns / 1ps

module homogeneous_vertex_transform (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [1:0]          coef_row,
	input  logic [1:0]          coef_col,
	input  logic signed [31:0]  coef_value,
	input  logic signed [31:0]  in_x,
	input  logic signed [31:0]  in_y,
	input  logic signed [31:0]  in_z,
	input  logic signed [31:0]  in_w,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic signed [31:0]  out_w,
	output logic                overflow
);

	hvt_pkg::mat_t      matrix;
	hvt_pkg::vec_t      vec;
	hvt_pkg::vec_t      result;
	hvt_pkg::sum_beat_t sum_beat;
	logic               dot_ready;
	logic               sat_ready;
	logic               in_take;
	logic               wr_en;
	logic               xf_load;

	// Stall ripples back only through full stages, so bubbles get squeezed out
	// and a waiting result does not block new beats until every stage is full.
	assign in_stall = !dot_ready;
	assign in_take  = in_valid && !in_stall;
	assign wr_en    = in_take && (cmd == hvt_pkg::CMD_WRITE);
	assign xf_load  = in_take && (cmd == hvt_pkg::CMD_XFORM);

	assign vec[0] = in_x;
	assign vec[1] = in_y;
	assign vec[2] = in_z;
	assign vec[3] = in_w;

	// Products are formed from the matrix as it stands at acceptance, so a
	// later coefficient write never leaks into a transform already in flight.
	hvt_coef_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_row   (coef_row),
		.wr_col   (coef_col),
		.wr_value (coef_value),
		.matrix   (matrix)
	);

	hvt_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (xf_load),
		.vec       (vec),
		.matrix    (matrix),
		.ready_in  (dot_ready),
		.ready_out (sat_ready),
		.beat      (sum_beat)
	);

	// Output register: sum >>> 16 (floor), clamp to 32 bits, flag per beat.
	hvt_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (sum_beat),
		.ready_in  (sat_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.overflow  (overflow)
	);

	assign out_x = result[0];
	assign out_y = result[1];
	assign out_z = result[2];
	assign out_w = result[3];

endmodule

/* hw/rtl/hvt_checker.sv */
// hvt_checker: port-level assertions for homogeneous_vertex_transform, bound below.
// Depends on hvt_pkg.
`timescale 1ns / 1ps

module hvt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z,
	input logic signed [31:0] out_w,
	input logic               overflow
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
			$stable(out_z) && $stable(out_w) && $stable(overflow))
		else $error("result beat changed while stalled");

	// the input side backs up only when the whole pipe is full behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// overflow only comes with a clamped component
	a_ovf_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
			out_x == hvt_pkg::WORD_MAX || out_x == hvt_pkg::WORD_MIN ||
			out_y == hvt_pkg::WORD_MAX || out_y == hvt_pkg::WORD_MIN ||
			out_z == hvt_pkg::WORD_MAX || out_z == hvt_pkg::WORD_MIN ||
			out_w == hvt_pkg::WORD_MAX || out_w == hvt_pkg::WORD_MIN)
		else $error("overflow set without saturated component");

	// nothing comes out in the first cycle after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind homogeneous_vertex_transform hvt_checker u_hvt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z),
	.out_w     (out_w),
	.overflow  (overflow)
);

/* tb/hvt_result_checker.sv */
// hvt_result_checker: watches both channels of homogeneous_vertex_transform,
// keeps its own copy of the matrix, predicts each transformed vertex and compares.
// Depends on hvt_pkg for the word type, command codes and fixed-point constants.
`timescale 1ns / 1ps

module hvt_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               cmd,
	input  logic [1:0]         coef_row,
	input  logic [1:0]         coef_col,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic signed [31:0] in_w,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_z,
	input  logic signed [31:0] out_w,
	input  logic               overflow,
	output int                 mismatches,
	output int                 pending,
	output int                 results_seen,
	output int                 overflows_seen
);

	typedef struct packed {
		hvt_pkg::word_t x;
		hvt_pkg::word_t y;
		hvt_pkg::word_t z;
		hvt_pkg::word_t w;
		logic           ovf;
	} vertex_res_t;

	localparam hvt_pkg::sum_t SAT_HI = 66'sd2147483647;
	localparam hvt_pkg::sum_t SAT_LO = -66'sd2147483648;
	localparam int   SHOW_MAX = 10;

	hvt_pkg::word_t matrix_shadow [4][4];
	vertex_res_t    expected_vertices [$];

	// full-precision dot products, floor shift, saturate per column
	function automatic vertex_res_t transform_vertex(input hvt_pkg::word_t vin [4]);
		vertex_res_t    res;
		hvt_pkg::word_t o [4];
		hvt_pkg::sum_t  acc;
		hvt_pkg::sum_t  a;
		hvt_pkg::sum_t  b;
		logic           sat;
		sat = 1'b0;
		for (int c = 0; c < 4; c++) begin
			acc = '0;
			for (int k = 0; k < 4; k++) begin
				a   = vin[k];
				b   = matrix_shadow[k][c];
				acc = acc + a * b;
			end
			acc = acc >>> hvt_pkg::FRAC_BITS;
			if (acc > SAT_HI) begin
				o[c] = hvt_pkg::WORD_MAX;
				sat  = 1'b1;
			end else if (acc < SAT_LO) begin
				o[c] = hvt_pkg::WORD_MIN;
				sat  = 1'b1;
			end else begin
				o[c] = acc[31:0];
			end
		end
		res.x   = o[0];
		res.y   = o[1];
		res.z   = o[2];
		res.w   = o[3];
		res.ovf = sat;
		return res;
	endfunction

	task automatic note_mismatch(input string what, input vertex_res_t exp_v,
			input vertex_res_t got_v);
		mismatches++;
		if (mismatches <= SHOW_MAX) begin
			$display("[%0t] %s: expected x=%h y=%h z=%h w=%h ovf=%b,",
				$time, what, exp_v.x, exp_v.y, exp_v.z, exp_v.w, exp_v.ovf);
			$display("    got x=%h y=%h z=%h w=%h ovf=%b",
				got_v.x, got_v.y, got_v.z, got_v.w, got_v.ovf);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		hvt_pkg::word_t vin [4];
		vertex_res_t    got_v;
		vertex_res_t    exp_v;
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					matrix_shadow[r][c] = (r == c) ? hvt_pkg::ONE : '0;
				end
			end
			expected_vertices.delete();
			mismatches     = 0;
			results_seen   = 0;
			overflows_seen = 0;
			pending        = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cmd == hvt_pkg::CMD_WRITE) begin
					matrix_shadow[coef_row][coef_col] = coef_value;
				end else begin
					vin[0] = in_x;
					vin[1] = in_y;
					vin[2] = in_z;
					vin[3] = in_w;
					expected_vertices.push_back(transform_vertex(vin));
				end
			end
			if (out_valid && !out_stall) begin
				got_v.x   = out_x;
				got_v.y   = out_y;
				got_v.z   = out_z;
				got_v.w   = out_w;
				got_v.ovf = overflow;
				results_seen++;
				if (overflow)
					overflows_seen++;
				if (expected_vertices.size() == 0) begin
					note_mismatch("unexpected result beat", '0, got_v);
				end else begin
					exp_v = expected_vertices.pop_front();
					if (exp_v.x !== got_v.x || exp_v.y !== got_v.y || exp_v.z !== got_v.z ||
							exp_v.w !== got_v.w || exp_v.ovf !== got_v.ovf)
						note_mismatch("result beat differs", exp_v, got_v);
				end
			end
			pending = expected_vertices.size();
		end
	end

endmodule

/* tb/tb_homogeneous_vertex_transform.sv */
// tb_homogeneous_vertex_transform: stimulus and verdict for the vertex transform.
// Depends on hvt_pkg, homogeneous_vertex_transform and hvt_result_checker.
`timescale 1ns / 1ps

module tb_homogeneous_vertex_transform;

	// run bounds
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int unsigned DRAIN_SLACK = 8;    // pipe depth is 4, plus margin
	localparam int unsigned IDLE_PCT    = 18;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [1:0]         coef_row;
	logic [1:0]         coef_col;
	logic signed [31:0] coef_value;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic signed [31:0] in_w;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic               overflow;

	int mismatches;
	int pending;
	int results_seen;
	int overflows_seen;

	// knobs for sender and receiver; written at falling edges, read by the receiver at rising
	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_req;

	int unsigned beats_sent;
	int unsigned writes_sent;
	int unsigned xforms_sent;
	int unsigned cycle_count;

	homogeneous_vertex_transform i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.coef_row   (coef_row),
		.coef_col   (coef_col),
		.coef_value (coef_value),
		.in_x       (in_x),
		.in_y       (in_y),
		.in_z       (in_z),
		.in_w       (in_w),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.overflow   (overflow)
	);

	hvt_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.coef_row       (coef_row),
		.coef_col       (coef_col),
		.coef_value     (coef_value),
		.in_x           (in_x),
		.in_y           (in_y),
		.in_z           (in_z),
		.in_w           (in_w),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.out_w          (out_w),
		.overflow       (overflow),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_seen   (results_seen),
		.overflows_seen (overflows_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung pipe or lost beat ends here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// receiver: decides at the rising edge, drives stall at the falling edge.
	// A hold request freezes the output for a hold-off counted down here.
	initial begin : receiver
		int unsigned hold_left;
		logic        nxt;
		bit          hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				nxt = 1'b1;
				hold_left--;
			end else begin
				nxt = rx_idle_on && ($urandom_range(99) < IDLE_PCT);
			end
			@(negedge clk);
			out_stall <= nxt;
		end
	end

	// Coefficient values: mostly small matrices, some full range, some corners.
	function automatic hvt_pkg::word_t pick_corner();
		case ($urandom_range(6))
			0: return hvt_pkg::WORD_MIN;
			1: return hvt_pkg::WORD_MAX;
			2: return '0;
			3: return 32'sd1;
			4: return -32'sd1;
			5: return hvt_pkg::ONE;
			default: return -hvt_pkg::ONE;
		endcase
	endfunction

	function automatic hvt_pkg::word_t pick_word(input int unsigned span);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return hvt_pkg::word_t'(int'($urandom_range(2 * span, 0)) - int'(span));
		else if (r < 85)
			return hvt_pkg::word_t'($urandom);
		else
			return pick_corner();
	endfunction

	// One beat on the input channel. Entered and left at a falling edge.
	// Sender gaps come first so in_valid is never dropped and raised in one step.
	task automatic send_beat(input hvt_pkg::cmd_t c, input logic [1:0] r,
			input logic [1:0] cl, input hvt_pkg::word_t v, input hvt_pkg::word_t x,
			input hvt_pkg::word_t y, input hvt_pkg::word_t z, input hvt_pkg::word_t w);
		if (tx_idle_on) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		cmd        <= c;
		coef_row   <= r;
		coef_col   <= cl;
		coef_value <= v;
		in_x       <= x;
		in_y       <= y;
		in_z       <= z;
		in_w       <= w;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		beats_sent++;
		if (c == hvt_pkg::CMD_WRITE)
			writes_sent++;
		else
			xforms_sent++;
	endtask

	// vertex fields on a write beat are junk; so are coef fields on a transform
	task automatic write_coef(input logic [1:0] r, input logic [1:0] cl,
			input hvt_pkg::word_t v);
		send_beat(hvt_pkg::CMD_WRITE, r, cl, v, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic xform(input hvt_pkg::word_t x, input hvt_pkg::word_t y,
			input hvt_pkg::word_t z, input hvt_pkg::word_t w);
		send_beat(hvt_pkg::CMD_XFORM, 2'($urandom_range(3)), 2'($urandom_range(3)),
			$urandom, x, y, z, w);
	endtask

	// hold the sender until every predicted vertex has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	// Mostly load-then-stream sequences, plus some fully random beats.
	task automatic random_traffic(input int unsigned n);
		int unsigned stop_at;
		int unsigned nw;
		int unsigned nt;
		bit          full_load;
		stop_at = beats_sent + n;
		while (beats_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				full_load = ($urandom_range(3) == 0);
				nw = full_load ? 16 : $urandom_range(6, 1);
				for (int i = 0; i < nw; i++) begin
					if (full_load)
						write_coef(2'(i / 4), 2'(i % 4), pick_word(4 * 65536));
					else
						write_coef(2'($urandom_range(3)), 2'($urandom_range(3)),
							pick_word(4 * 65536));
				end
				nt = $urandom_range(30, 4);
				for (int i = 0; i < nt; i++) begin
					xform(pick_word(1 << 26), pick_word(1 << 26), pick_word(1 << 26),
						pick_word(1 << 26));
				end
			end else begin
				send_beat(hvt_pkg::cmd_t'($urandom_range(1)), 2'($urandom_range(3)),
					2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
					$urandom);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		cmd         = hvt_pkg::CMD_WRITE;
		coef_row    = '0;
		coef_col    = '0;
		coef_value  = '0;
		in_x        = '0;
		in_y        = '0;
		in_z        = '0;
		in_w        = '0;
		tx_idle_on  = 1'b1;
		rx_idle_on  = 1'b1;
		hold_req    = 1'b0;
		beats_sent  = 0;
		writes_sent = 0;
		xforms_sent = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// identity after reset, ordinary and extreme vertices pass unchanged
		xform(32'sh0001_0000, 32'shFFFE_0000, 32'sh0003_8000, hvt_pkg::ONE);
		xform(hvt_pkg::WORD_MAX, hvt_pkg::WORD_MIN, '0, -32'sd1);
		// translation in row 3
		write_coef(2'd3, 2'd0, 32'sh000A_0000);
		write_coef(2'd3, 2'd1, 32'shFFFB_0000);
		write_coef(2'd3, 2'd2, 32'sh0000_8000);
		xform(hvt_pkg::ONE, 32'sh0002_0000, 32'sh0003_0000, hvt_pkg::ONE);
		// saturation both ways through the most negative coefficient
		write_coef(2'd0, 2'd0, hvt_pkg::WORD_MIN);
		xform(hvt_pkg::WORD_MIN, '0, '0, '0);
		xform(hvt_pkg::WORD_MAX, '0, '0, '0);
		// floor shift: -1 * 2^-16 rounds down to -1, +1 * 2^-16 to 0
		write_coef(2'd0, 2'd0, 32'sd1);
		xform(-32'sd1, '0, '0, '0);
		xform(32'sd1, '0, '0, '0);
		// largest possible sum: four products of min by min in column 3
		write_coef(2'd0, 2'd3, hvt_pkg::WORD_MIN);
		write_coef(2'd1, 2'd3, hvt_pkg::WORD_MIN);
		write_coef(2'd2, 2'd3, hvt_pkg::WORD_MIN);
		write_coef(2'd3, 2'd3, hvt_pkg::WORD_MIN);
		xform(hvt_pkg::WORD_MIN, hvt_pkg::WORD_MIN, hvt_pkg::WORD_MIN, hvt_pkg::WORD_MIN);
		xform(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
		// flag is per result: a clean vertex right after a saturated one
		write_coef(2'd3, 2'd3, hvt_pkg::ONE);
		write_coef(2'd0, 2'd3, '0);
		xform(hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX);
		xform('0, '0, '0, '0);
		wait_drain();

		// --- random, idling on both sides ---
		random_traffic(600);

		// long stretch with no idling at all
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_traffic(300);
		wait_drain();

		// receiver holds off while the sender keeps pushing: pipe fills, in_stall rises
		rx_idle_on = 1'b1;
		hold_req   = 1'b1;
		random_traffic(150);
		wait_drain();

		tx_idle_on = 1'b1;
		random_traffic(800);

		// --- wind down ---
		wait_drain();

		$display("Sent %0d beats: %0d coefficient writes, %0d vertex transforms.",
			beats_sent, writes_sent, xforms_sent);
		$display("Compared %0d result beats (%0d saturated)", results_seen, overflows_seen);
		$display("across idle, hold-off and drain phases.");
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/hvt_pkg.sv
hw/rtl/hvt_coef_store.sv
hw/rtl/hvt_dot.sv
hw/rtl/hvt_sat.sv
hw/rtl/homogeneous_vertex_transform.sv
hw/rtl/hvt_checker.sv
tb/hvt_result_checker.sv
tb/tb_homogeneous_vertex_transform.sv
